FILE: rtl/core/utf8v_pkg.sv
// Shared types and constants for the UTF-8 stream validator.
package utf8v_pkg;

	// Input command codes
	localparam logic CMD_DATA = 1'b0;
	localparam logic CMD_END  = 1'b1;

	// Code point limits
	localparam logic [20:0] CP_MIN_THREE  = 21'h000800;
	localparam logic [20:0] CP_MIN_FOUR   = 21'h010000;
	localparam logic [20:0] CP_SURR_LO    = 21'h00D800;
	localparam logic [20:0] CP_SURR_HI    = 21'h00DFFF;
	localparam logic [20:0] CP_MAX        = 21'h10FFFF;

	// Sequence lengths, counted in continuation bytes
	localparam logic [1:0] SEQ_NONE  = 2'd0;
	localparam logic [1:0] SEQ_TWO   = 2'd1;
	localparam logic [1:0] SEQ_THREE = 2'd2;
	localparam logic [1:0] SEQ_FOUR  = 2'd3;

	typedef enum logic [1:0] {
		VERDICT_OK    = 2'd0,
		VERDICT_EMPTY = 2'd1,
		VERDICT_NUL   = 2'd2,
		VERDICT_BAD   = 2'd3
	} verdict_t;

	typedef struct packed {
		logic        seen_byte;
		logic        seen_nul;
		logic        encoding_bad;
		logic [1:0]  bytes_pending;
		logic [1:0]  sequence_length;
		logic [20:0] partial_code_point;
	} scan_state_t;

	localparam scan_state_t SCAN_CLEAR = '0;

endpackage

FILE: rtl/core/utf8v_decode.sv
// Next-state decode of the scan state for one data byte.
module utf8v_decode import utf8v_pkg::*; (
	input  scan_state_t cur,
	input  logic [7:0]  data_byte,
	output scan_state_t nxt
);

	logic [20:0] cp_shift;

	// Gather six more code point bits from a continuation byte
	assign cp_shift = {cur.partial_code_point[14:0], data_byte[5:0]};

	always_comb begin
		nxt = cur;
		nxt.seen_byte = 1'b1;
		if (data_byte == 8'h00) begin
			nxt.seen_nul = 1'b1;
		end
		// Decode only while the encoding is still clean
		if (!cur.encoding_bad) begin
			if (cur.bytes_pending != 2'd0) begin
				if (data_byte[7:6] != 2'b10) begin
					// Drop the open sequence on a bad continuation byte
					nxt.encoding_bad       = 1'b1;
					nxt.bytes_pending      = 2'd0;
					nxt.sequence_length    = SEQ_NONE;
					nxt.partial_code_point = '0;
				end else if (cur.bytes_pending == 2'd1) begin
					// Close the sequence and check overlong, surrogate and range
					if ((cur.sequence_length == SEQ_THREE && cp_shift < CP_MIN_THREE) ||
					    (cur.sequence_length == SEQ_FOUR && cp_shift < CP_MIN_FOUR) ||
					    (cp_shift >= CP_SURR_LO && cp_shift <= CP_SURR_HI) ||
					    (cp_shift > CP_MAX)) begin
						nxt.encoding_bad = 1'b1;
					end
					nxt.bytes_pending      = 2'd0;
					nxt.sequence_length    = SEQ_NONE;
					nxt.partial_code_point = '0;
				end else begin
					nxt.bytes_pending      = cur.bytes_pending - 2'd1;
					nxt.partial_code_point = cp_shift;
				end
			end else begin
				// Classify a lead byte
				case (data_byte) inside
					[8'h00:8'h7F]: begin
					end
					[8'hC2:8'hDF]: begin
						nxt.sequence_length    = SEQ_TWO;
						nxt.bytes_pending      = SEQ_TWO;
						nxt.partial_code_point = {16'd0, data_byte[4:0]};
					end
					[8'hE0:8'hEF]: begin
						nxt.sequence_length    = SEQ_THREE;
						nxt.bytes_pending      = SEQ_THREE;
						nxt.partial_code_point = {17'd0, data_byte[3:0]};
					end
					[8'hF0:8'hF4]: begin
						nxt.sequence_length    = SEQ_FOUR;
						nxt.bytes_pending      = SEQ_FOUR;
						nxt.partial_code_point = {18'd0, data_byte[2:0]};
					end
					default: begin
						nxt.encoding_bad = 1'b1;
					end
				endcase
			end
		end
	end

endmodule

FILE: rtl/core/utf8_stream_validator_top.sv
// Top level of the UTF-8 stream validator: input register, scan state and verdict register.
// An end item passes from the input register to the verdict register, which drives out_valid.
// Throughput: one item per cycle; a data item never stalls in the input register, an end
// item waits there while the verdict register is full and out_ready is low, holding input.
// Reset: arst_n (asynchronous, active low) empties both registers and clears the scan state.
// The scan state also returns to its cleared value after every end item.
module utf8_stream_validator_top import utf8v_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       command,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] verdict
);

	logic        valid_s1;
	logic        command_s1;
	logic [7:0]  byte_s1;
	logic        advance;
	logic        end_go;
	scan_state_t state_q;
	scan_state_t state_next;
	logic        out_valid_q;
	verdict_t    verdict_q;
	verdict_t    verdict_new;

	// Advance stage one unless an end item meets a full verdict register
	assign advance  = valid_s1 && (command_s1 == CMD_DATA || !out_valid_q || out_ready);
	assign end_go   = advance && command_s1 == CMD_END;
	assign in_ready = !valid_s1 || advance;

	// Hold the accepted item in stage one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			command_s1 <= command;
			byte_s1    <= data_byte;
		end
	end

	utf8v_decode u_decode (
		.cur       (state_q),
		.data_byte (byte_s1),
		.nxt       (state_next)
	);

	// Pick the verdict by priority; an open sequence counts as invalid
	always_comb begin
		if (!state_q.seen_byte) begin
			verdict_new = VERDICT_EMPTY;
		end else if (state_q.seen_nul) begin
			verdict_new = VERDICT_NUL;
		end else if (state_q.encoding_bad || state_q.bytes_pending != 2'd0) begin
			verdict_new = VERDICT_BAD;
		end else begin
			verdict_new = VERDICT_OK;
		end
	end

	// Update the scan state; clear it after an end item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SCAN_CLEAR;
		end else if (end_go) begin
			state_q <= SCAN_CLEAR;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	// Load the verdict register; drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (end_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (end_go) begin
			verdict_q <= verdict_new;
		end
	end

	assign out_valid = out_valid_q;
	assign verdict   = verdict_q;

	// A pending count never exceeds the length of its open sequence
	a_pending_in_seq: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.bytes_pending != 2'd0 |-> state_q.bytes_pending <= state_q.sequence_length)
		else $error("bytes_pending exceeds sequence_length");

	// Decoding stops after an encoding error
	a_bad_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.encoding_bad |-> state_q.bytes_pending == 2'd0)
		else $error("sequence still open after encoding error");

	// Without a data byte the scan state stays clear
	a_empty_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!state_q.seen_byte |-> state_q == SCAN_CLEAR)
		else $error("scan state dirty with no byte seen");

	// An end item clears the state and presents a verdict
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		end_go |=> state_q == SCAN_CLEAR && out_valid_q)
		else $error("end item did not clear state or load verdict");

	// An empty input register always takes an item
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("stage one empty but not ready");

endmodule
